[rtl/ptt_pkg.sv]
package ptt_pkg;

  localparam int DEFAULT_SLOTS = 16;

  localparam logic [2:0] ACT_SET      = 3'd0;
  localparam logic [2:0] ACT_ACTIVATE = 3'd1;
  localparam logic [2:0] ACT_STOP     = 3'd2;
  localparam logic [2:0] ACT_QUERY    = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;
  localparam logic [2:0] ACT_STOP_ALL = 3'd5;
  localparam logic [2:0] ACT_CLEAR    = 3'd6;

  localparam logic [1:0] KIND_DONE      = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_TICK_DONE = 2'd2;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] timer_id;
    logic [31:0] interval;
    logic        enable;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] fired_id;
    logic        found;
    logic        hit;
    logic        is_valid;
    logic        is_active;
    logic [4:0]  live_count;
    logic        table_full;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] last_fire;
  } slot_entry_t;

endpackage

[rtl/periodic_timer_table.sv]
// Channel | Signals                      | Payload
// --------+------------------------------+-----------------------------
// input   | in_valid, in_ready, in_data  | ptt_pkg::in_t (one command)
// output  | out_valid, out_ready, out_data| ptt_pkg::out_t (one result)
//
// Set, activate, stop, query and tick walk all TIMER_SLOTS entries of the slot
// RAM, each slot read in S_READ and then compared in S_EVAL; the command is
// accepted in S_IDLE and the final result is delivered from S_DONE. Stop all,
// clear and unused codes go straight to S_DONE. One item is in work at a time.
// A stalled output holds the walk at a firing slot or at the final result.
// Reset clears the used, valid and running bits at once; no clearing pass.
module periodic_timer_table #(
  parameter int TIMER_SLOTS = ptt_pkg::DEFAULT_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ptt_pkg::out_t out_data
);

  import ptt_pkg::*;

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_DONE} state_t;

  state_t             state;
  in_t                cmd;
  logic [IDX_W-1:0]   idx;
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [4:0]         live_cnt;
  logic [TIMER_SLOTS-1:0] slot_used;
  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [TIMER_SLOTS-1:0] slot_running;

  logic                      out_free;
  logic                      is_tick;
  logic                      tick_live;
  logic                      fire;
  logic                      advance;
  logic                      load_out;
  logic [31:0]               elapsed;
  slot_entry_t               entry;
  logic [$bits(slot_entry_t)-1:0] rd_data;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  slot_entry_t               wr_entry;
  out_t                      fired_result;
  out_t                      done_result;

  ptt_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (TIMER_SLOTS),
    .ADDR_W(IDX_W)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  assign entry     = slot_entry_t'(rd_data);
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign is_tick   = (cmd.action == ACT_TICK);
  assign elapsed   = cmd.now - entry.last_fire;
  assign tick_live = slot_used[idx] && slot_valid[idx] && slot_running[idx];
  assign fire      = tick_live && (cmd.now > entry.last_fire) && (elapsed >= entry.period);
  // A firing slot waits in place until the output register can take its result.
  assign advance   = (state == S_EVAL) && !(is_tick && fire && !out_free);
  assign load_out  = (advance && is_tick && fire) || (state == S_DONE && out_free);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_entry = entry;
    wr_entry.last_fire = cmd.now;
    if (state == S_EVAL && is_tick && fire && out_free) begin
      wr_en = 1'b1;
    end else if (state == S_DONE && out_free && cmd.action == ACT_SET &&
                 cmd.interval != 32'd0 && (match_found || free_found)) begin
      wr_en    = 1'b1;
      wr_addr  = match_found ? match_idx : free_idx;
      wr_entry = '{id: cmd.timer_id, period: cmd.interval, last_fire: cmd.now};
    end
  end

  always_comb begin
    fired_result          = '0;
    fired_result.kind     = KIND_FIRED;
    fired_result.fired_id = entry.id;

    done_result      = '0;
    done_result.last = 1'b1;
    done_result.kind = is_tick ? KIND_TICK_DONE : KIND_DONE;
    done_result.hit  = match_found;
    if (cmd.action == ACT_QUERY && match_found) begin
      done_result.is_valid  = slot_valid[match_idx];
      done_result.is_active = slot_running[match_idx];
    end
    if (is_tick) begin
      done_result.live_count = live_cnt;
    end
    done_result.table_full = (cmd.action == ACT_SET) && (cmd.interval != 32'd0) &&
                             !match_found && !free_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      slot_used    <= '0;
      slot_valid   <= '0;
      slot_running <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd         <= in_data;
            idx         <= '0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            live_cnt    <= '0;
            unique case (in_data.action)
              ACT_STOP_ALL: begin
                slot_valid <= '0;
                state      <= S_DONE;
              end
              ACT_CLEAR: begin
                slot_used    <= '0;
                slot_valid   <= '0;
                slot_running <= '0;
                state        <= S_DONE;
              end
              ACT_SET, ACT_ACTIVATE, ACT_STOP, ACT_QUERY, ACT_TICK: begin
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (advance) begin
            if (is_tick) begin
              // Stopped timers give up their slot as the tick passes over them.
              if (slot_used[idx] && !slot_valid[idx]) begin
                slot_used[idx]    <= 1'b0;
                slot_running[idx] <= 1'b0;
              end
              if (tick_live && live_cnt != COUNT_MAX) begin
                live_cnt <= live_cnt + 5'd1;
              end
              if (fire) begin
                out_data <= fired_result;
              end
            end else begin
              if (slot_used[idx] && entry.id == cmd.timer_id && !match_found) begin
                match_found <= 1'b1;
                match_idx   <= idx;
              end
              if (!slot_used[idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= idx;
              end
            end
            if (idx == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data  <= done_result;
            state     <= S_IDLE;
            if (cmd.action == ACT_SET) begin
              if (cmd.interval == 32'd0) begin
                if (match_found) begin
                  slot_valid[match_idx] <= 1'b0;
                end
              end else if (match_found) begin
                slot_valid[match_idx] <= 1'b1;
              end else if (free_found) begin
                slot_used[free_idx]    <= 1'b1;
                slot_valid[free_idx]   <= 1'b1;
                slot_running[free_idx] <= 1'b1;
              end
            end else if (cmd.action == ACT_ACTIVATE && match_found) begin
              slot_running[match_idx] <= cmd.enable;
            end else if (cmd.action == ACT_STOP && match_found) begin
              slot_valid[match_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_valid_needs_used: assert property (@(posedge clk) disable iff (rst)
    (slot_valid & ~slot_used) == '0)
    else $error("valid bit set on a free slot");

  a_running_needs_used: assert property (@(posedge clk) disable iff (rst)
    (slot_running & ~slot_used) == '0)
    else $error("running bit set on a free slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transaction taken while one is in work");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_FIRED) |-> !out_data.last)
    else $error("fired result marked as final");

  a_tick_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_TICK_DONE) |-> out_data.last)
    else $error("tick summary not marked as final");

endmodule

[rtl/ptt_ram.sv]
module ptt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ptt_pkg::*;

  localparam int SLOTS = DEFAULT_SLOTS;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int POOL_SIZE = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  periodic_timer_table #(.TIMER_SLOTS(SLOTS)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Predicted timer table.
  logic        timer_used [SLOTS];
  logic [31:0] timer_id [SLOTS];
  logic [31:0] timer_period [SLOTS];
  logic [31:0] timer_last_fire [SLOTS];
  logic        timer_valid [SLOTS];
  logic        timer_running [SLOTS];

  out_t pending_results[$];
  out_t want;
  int errors = 0;
  bit calm = 1'b0;
  int ready_hold = 0;

  logic [31:0] id_pool [POOL_SIZE];
  logic [31:0] clock_secs;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t make_cmd(logic [2:0] action, logic [31:0] id,
                                   logic [31:0] interval, logic enable,
                                   logic [31:0] now);
    in_t c;
    c.action = action;
    c.timer_id = id;
    c.interval = interval;
    c.enable = enable;
    c.now = now;
    return c;
  endfunction

  function automatic void predict_results(in_t cmd);
    int slot;
    int free_slot;
    int count;
    out_t r;
    slot = -1;
    free_slot = -1;
    count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && timer_used[i] && timer_id[i] == cmd.timer_id) slot = i;
      if (free_slot < 0 && !timer_used[i]) free_slot = i;
    end
    r = '0;
    r.kind = KIND_DONE;
    r.last = 1'b1;
    case (cmd.action)
      ACT_SET: begin
        r.hit = (slot >= 0);
        if (cmd.interval == 32'd0) begin
          if (slot >= 0) timer_valid[slot] = 1'b0;
        end else if (slot >= 0) begin
          timer_period[slot] = cmd.interval;
          timer_valid[slot] = 1'b1;
          timer_last_fire[slot] = cmd.now;
        end else if (free_slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          timer_used[free_slot] = 1'b1;
          timer_id[free_slot] = cmd.timer_id;
          timer_running[free_slot] = 1'b1;
          timer_period[free_slot] = cmd.interval;
          timer_valid[free_slot] = 1'b1;
          timer_last_fire[free_slot] = cmd.now;
        end
      end
      ACT_ACTIVATE: begin
        r.hit = (slot >= 0);
        if (slot >= 0) timer_running[slot] = cmd.enable;
      end
      ACT_STOP: begin
        r.hit = (slot >= 0);
        if (slot >= 0) timer_valid[slot] = 1'b0;
      end
      ACT_QUERY: begin
        r.hit = (slot >= 0);
        if (slot >= 0) begin
          r.is_valid = timer_valid[slot];
          r.is_active = timer_running[slot];
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (timer_used[i] && !timer_valid[i]) begin
            timer_used[i] = 1'b0;
            timer_running[i] = 1'b0;
          end else if (timer_used[i] && timer_running[i]) begin
            count++;
            if (cmd.now > timer_last_fire[i] &&
                cmd.now - timer_last_fire[i] >= timer_period[i]) begin
              out_t f;
              f = '0;
              f.kind = KIND_FIRED;
              f.fired_id = timer_id[i];
              pending_results.insert(pending_results.size(), f);
              timer_last_fire[i] = cmd.now;
            end
          end
        end
        r.kind = KIND_TICK_DONE;
        r.live_count = (count > 31) ? COUNT_MAX : 5'(count);
      end
      ACT_STOP_ALL: begin
        for (int i = 0; i < SLOTS; i++)
          if (timer_used[i]) timer_valid[i] = 1'b0;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          timer_used[i] = 1'b0;
          timer_valid[i] = 1'b0;
          timer_running[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    pending_results.insert(pending_results.size(), r);
  endfunction

  // A zero gap keeps valid high straight into the next transaction.
  task automatic send_cmd(input in_t cmd);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_results(cmd);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        ready_hold = pick_gap();
      end else begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(1, 12);
      end
    end else begin
      ready_hold = ready_hold - 1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("fired_id", want.fired_id, out_data.fired_id);
        check_field("found", 32'(want.found), 32'(out_data.found));
        check_field("hit", 32'(want.hit), 32'(out_data.hit));
        check_field("is_valid", 32'(want.is_valid), 32'(out_data.is_valid));
        check_field("is_active", 32'(want.is_active), 32'(out_data.is_active));
        check_field("live_count", 32'(want.live_count), 32'(out_data.live_count));
        check_field("table_full", 32'(want.table_full), 32'(out_data.table_full));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  task automatic test_set_and_query();
    send_cmd(make_cmd(ACT_SET, 32'h0, 32'd1, 1'b0, 32'h0));
    send_cmd(make_cmd(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ACT_SET, 32'h0, 32'd3, 1'b0, 32'd2));
    send_cmd(make_cmd(ACT_QUERY, 32'h1234_5678, 32'h0, 1'b1, 32'h0));
  endtask

  task automatic test_activate_and_stop();
    send_cmd(make_cmd(ACT_ACTIVATE, 32'h0, 32'h0, 1'b0, 32'h0));
    send_cmd(make_cmd(ACT_ACTIVATE, 32'h0000_DEAD, 32'h0, 1'b1, 32'h0));
    send_cmd(make_cmd(ACT_STOP, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0));
    send_cmd(make_cmd(ACT_QUERY, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0));
    // A stopped timer that has not been purged yet comes back on set.
    send_cmd(make_cmd(ACT_SET, 32'hFFFF_FFFF, 32'd5, 1'b0, 32'd10));
    send_cmd(make_cmd(ACT_SET, 32'h0, 32'd0, 1'b0, 32'd11));
  endtask

  task automatic test_tick();
    send_cmd(make_cmd(ACT_TICK, 32'h0, 32'h0, 1'b0, 32'd20));
    send_cmd(make_cmd(ACT_TICK, 32'h0, 32'h0, 1'b0, 32'd20));
    send_cmd(make_cmd(ACT_TICK, 32'h0, 32'h0, 1'b0, 32'd0));
  endtask

  task automatic test_full_table();
    int free_slots;
    free_slots = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!timer_used[i]) free_slots++;
    // One more new ID than there are free slots, so the last set is refused.
    for (int k = 0; k <= free_slots; k++)
      send_cmd(make_cmd(ACT_SET, 32'h1000 + k, k + 1, 1'b1, 32'd100));
    send_cmd(make_cmd(ACT_TICK, 32'h0, 32'h0, 1'b0, 32'd200));
  endtask

  task automatic test_stop_all_and_clear();
    send_cmd(make_cmd(ACT_STOP_ALL, 32'h0, 32'h0, 1'b0, 32'h0));
    send_cmd(make_cmd(ACT_TICK, 32'h0, 32'h0, 1'b0, 32'd300));
    send_cmd(make_cmd(ACT_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ACT_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0));
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic in_t random_cmd();
    in_t c;
    int r;
    int pick;
    r = $urandom_range(0, 99);
    c.timer_id = pick_id();
    c.interval = $urandom;
    c.enable = 1'($urandom_range(0, 1));
    c.now = $urandom;
    clock_secs = clock_secs + $urandom_range(0, 3);
    if (r < 30) begin
      c.action = ACT_SET;
      pick = $urandom_range(0, 19);
      if (pick == 0) c.interval = 32'd0;
      else if (pick > 1) c.interval = $urandom_range(1, 8);
      if ($urandom_range(0, 19) != 0) c.now = clock_secs;
    end else if (r < 42) begin
      c.action = ACT_ACTIVATE;
      c.enable = ($urandom_range(0, 3) != 0);
    end else if (r < 50) begin
      c.action = ACT_STOP;
    end else if (r < 64) begin
      c.action = ACT_QUERY;
    end else if (r < 91) begin
      c.action = ACT_TICK;
      if ($urandom_range(0, 19) != 0) c.now = clock_secs;
    end else if (r < 94) begin
      c.action = ACT_STOP_ALL;
    end else if (r < 96) begin
      c.action = ACT_CLEAR;
    end else begin
      c.action = ACT_UNUSED;
    end
    return c;
  endfunction

  task automatic test_random_traffic(input int count, input logic [31:0] start_secs,
                                     input bit no_idle);
    calm = no_idle;
    clock_secs = start_secs;
    repeat (count) send_cmd(random_cmd());
    wait_for_results();
    calm = 1'b0;
  endtask

  initial begin
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    for (int i = 0; i < SLOTS; i++) begin
      timer_used[i] = 1'b0;
      timer_id[i] = '0;
      timer_period[i] = '0;
      timer_last_fire[i] = '0;
      timer_valid[i] = 1'b0;
      timer_running[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_set_and_query();
    test_activate_and_stop();
    test_tick();
    wait_for_results();
    calm = 1'b1;
    test_full_table();
    wait_for_results();
    calm = 1'b0;
    test_stop_all_and_clear();
    wait_for_results();

    test_random_traffic(55, 32'd100, 1'b0);
    // Time starts 64 below the 32-bit wrap here, so it usually runs across it.
    test_random_traffic(50, 32'hFFFF_FFC0, 1'b0);
    test_random_traffic(35, 32'd5000, 1'b1);
    test_random_traffic(35, $urandom, 1'b0);

    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
